// ===== rtl/wcc_pkg.sv =====
// Shared types, constants and command codes of the weighted centroid block.
`default_nettype none
package wcc_pkg;

  localparam int DEF_POS_FRAC_BITS = 8;
  localparam int DEF_COUNT_BITS    = 16;

  localparam int VAR_FRAC  = 16;
  localparam int CEN_EXTRA = 16;
  localparam int VAR_W     = 48;
  localparam int SIG_W     = 23;

  localparam logic [VAR_W-1:0] VAR_MAX   = '1;
  localparam logic [SIG_W-1:0] SIGMA_MAX = '1;
  localparam logic [VAR_W-1:0] DEF_VAR_X = VAR_W'(4 * 4) << VAR_FRAC;
  localparam logic [VAR_W-1:0] DEF_VAR_Y = VAR_W'(1 * 1) << VAR_FRAC;
  localparam logic [VAR_W-1:0] DEF_VAR_Z = VAR_W'(6 * 6) << VAR_FRAC;

  // cluster type codes; code three behaves as a layer cluster
  localparam logic [1:0] AXIS_NONE  = 2'd0;
  localparam logic [1:0] AXIS_LAYER = 2'd1;
  localparam logic [1:0] AXIS_ROW   = 2'd2;
  localparam logic [1:0] AXIS_BOTH  = 2'd3;

  typedef struct packed {
    logic               first_hit;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] path_s;
    logic [19:0]        hit_charge;
    logic [1:0]         fixed_axis;
    logic               embed_in;
  } hit_t;

  typedef struct packed {
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [23:0] mean_z;
    logic signed [23:0] mean_s;
    logic [22:0]        sigma_x;
    logic [22:0]        sigma_y;
    logic [22:0]        sigma_z;
    logic [31:0]        total_charge;
    logic [15:0]        hit_count;
    logic               embed_out;
    logic               bad_charge;
  } res_t;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_LOAD    = 5'd1;
  localparam op_t OP_PREP    = 5'd2;
  localparam op_t OP_CMUL    = 5'd3;
  localparam op_t OP_CDIV    = 5'd4;
  localparam op_t OP_CUPD    = 5'd5;
  localparam op_t OP_VDEF    = 5'd6;
  localparam op_t OP_WW_MUL  = 5'd7;
  localparam op_t OP_WN2_MUL = 5'd8;
  localparam op_t OP_WN2_WB  = 5'd9;
  localparam op_t OP_SQ_MUL  = 5'd10;
  localparam op_t OP_TM_MUL  = 5'd11;
  localparam op_t OP_TM_DIV  = 5'd12;
  localparam op_t OP_TM_WB   = 5'd13;
  localparam op_t OP_OV_MUL  = 5'd14;
  localparam op_t OP_OV_DIV  = 5'd15;
  localparam op_t OP_VUPD    = 5'd16;
  localparam op_t OP_COMMIT  = 5'd17;
  localparam op_t OP_SQRT    = 5'd18;
  localparam op_t OP_SG_WB   = 5'd19;
  localparam op_t OP_EMIT    = 5'd20;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic cnt_zero;
    logic cnt_one;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/wcc_hit_if.sv =====
// Input channel carrying one detector hit per transaction.
`default_nettype none
interface wcc_hit_if;
  import wcc_pkg::*;
  logic valid;
  logic ready;
  hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wcc_res_if.sv =====
// Output channel carrying one cluster summary per transaction.
`default_nettype none
interface wcc_res_if;
  import wcc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wcc_ctrl.sv =====
// Sequencer stepping the datapath through one hit.
`default_nettype none
module wcc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          hit_valid,
  output logic               hit_ready,
  input  wire wcc_pkg::sts_t sts,
  output wcc_pkg::cmd_t      cmd
);
  import wcc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PREP   = 5'd1;
  localparam logic [4:0] S_CMUL   = 5'd2;
  localparam logic [4:0] S_CMUL_W = 5'd3;
  localparam logic [4:0] S_CDIV_W = 5'd4;
  localparam logic [4:0] S_VDEF   = 5'd5;
  localparam logic [4:0] S_WW     = 5'd6;
  localparam logic [4:0] S_WW_W   = 5'd7;
  localparam logic [4:0] S_WN2_W  = 5'd8;
  localparam logic [4:0] S_SQ     = 5'd9;
  localparam logic [4:0] S_SQ_W   = 5'd10;
  localparam logic [4:0] S_TM_W   = 5'd11;
  localparam logic [4:0] S_TMD_W  = 5'd12;
  localparam logic [4:0] S_OV     = 5'd13;
  localparam logic [4:0] S_OV_W   = 5'd14;
  localparam logic [4:0] S_OVD_W  = 5'd15;
  localparam logic [4:0] S_VUPD   = 5'd16;
  localparam logic [4:0] S_COMMIT = 5'd17;
  localparam logic [4:0] S_SQRT   = 5'd18;
  localparam logic [4:0] S_SQRT_W = 5'd19;
  localparam logic [4:0] S_EMIT   = 5'd20;

  logic [4:0] state, state_next;
  logic [1:0] idx, idx_next;

  assign hit_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = 2'd0;
        if (hit_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        state_next = sts.bad ? S_SQRT : S_CMUL;
      end
      S_CMUL: begin
        cmd.op     = OP_CMUL;
        state_next = S_CMUL_W;
      end
      S_CMUL_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_CDIV;
          state_next = S_CDIV_W;
        end
      end
      S_CDIV_W: begin
        if (sts.div_done) begin
          cmd.op = OP_CUPD;
          if (idx == 2'd3) begin
            idx_next   = 2'd0;
            state_next = sts.cnt_zero ? S_VDEF : S_WW;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_CMUL;
          end
        end
      end
      S_VDEF: begin
        cmd.op     = OP_VDEF;
        state_next = S_COMMIT;
      end
      S_WW: begin
        cmd.op     = OP_WW_MUL;
        state_next = S_WW_W;
      end
      S_WW_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_WN2_MUL;
          state_next = S_WN2_W;
        end
      end
      S_WN2_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_WN2_WB;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op     = OP_SQ_MUL;
        state_next = S_SQ_W;
      end
      S_SQ_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_TM_MUL;
          state_next = S_TM_W;
        end
      end
      S_TM_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_TM_DIV;
          state_next = S_TMD_W;
        end
      end
      S_TMD_W: begin
        if (sts.div_done) begin
          cmd.op     = OP_TM_WB;
          state_next = sts.cnt_one ? S_VUPD : S_OV;
        end
      end
      S_OV: begin
        cmd.op     = OP_OV_MUL;
        state_next = S_OV_W;
      end
      S_OV_W: begin
        if (sts.mul_done) begin
          cmd.op     = OP_OV_DIV;
          state_next = S_OVD_W;
        end
      end
      S_OVD_W, S_VUPD: begin
        if (state == S_VUPD || sts.div_done) begin
          cmd.op = OP_VUPD;
          if (idx == 2'd2) begin
            idx_next   = 2'd0;
            state_next = S_COMMIT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_SQ;
          end
        end
      end
      S_COMMIT: begin
        cmd.op     = OP_COMMIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (sts.sqrt_done) begin
          cmd.op = OP_SG_WB;
          if (idx == 2'd2) begin
            idx_next   = 2'd0;
            state_next = S_EMIT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_SQRT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // unit completions only arrive where the sequencer waits for them
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_CMUL_W || state == S_WW_W || state == S_WN2_W ||
                      state == S_SQ_W || state == S_TM_W || state == S_OV_W))
    else $error("multiplier finished outside a wait state");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_CDIV_W || state == S_TMD_W || state == S_OVD_W))
    else $error("divider finished outside a wait state");
  a_bad_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP && sts.bad) |=> state == S_SQRT)
    else $error("rejected hit entered the update sequence");

endmodule
`default_nettype wire

// ===== rtl/wcc_dp.sv =====
// Datapath: cluster state, shared multiplier, divider and square root units.
`default_nettype none
module wcc_dp #(
  parameter int POS_FRAC_BITS = wcc_pkg::DEF_POS_FRAC_BITS,
  parameter int COUNT_BITS    = wcc_pkg::DEF_COUNT_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wcc_pkg::cmd_t cmd,
  input  wire wcc_pkg::hit_t hit_data,
  output wcc_pkg::sts_t      sts,
  output wcc_pkg::res_t      res_data,
  output logic               res_valid,
  input  wire logic          res_ready
);
  import wcc_pkg::*;

  localparam int SQ_SH = 2 * POS_FRAC_BITS + VAR_FRAC;
  localparam int SH_L  = (2 * POS_FRAC_BITS >= VAR_FRAC) ? 2 * POS_FRAC_BITS - VAR_FRAC : 0;
  localparam int SH_R  = (2 * POS_FRAC_BITS >= VAR_FRAC) ? 0 : VAR_FRAC - 2 * POS_FRAC_BITS;

  // cluster state
  hit_t                   h;
  logic [31:0]            cs;
  logic signed [39:0]     cen [4];
  logic [VAR_W-1:0]       vr [3];
  logic [COUNT_BITS-1:0]  cnt;
  logic                   emb;

  // per-hit working registers
  logic [31:0]      wo, wn;
  logic [51:0]      ww;
  logic [63:0]      wn2;
  logic [VAR_W-1:0] term;
  logic [39:0]      dmag [3];
  logic             dneg;
  logic [SIG_W-1:0] sig [3];

  // multiplier, 16 bits of the second operand per cycle
  logic [63:0]  ma, mb;
  logic [127:0] acc;
  logic [1:0]   mcnt;
  logic         mbusy, mdone;

  // restoring divider, one quotient bit per cycle
  logic [63:0]  dd, rem;
  logic [47:0]  dlow, dq;
  logic [5:0]   dcnt;
  logic         dbusy, ddone;

  // square root, one result bit per cycle
  logic [63:0]  sv, sr, sb;
  logic [4:0]   scnt;
  logic         sbusy, sdone;

  // operand selection
  logic signed [23:0]  pos_sel;
  logic signed [40:0]  diff;
  logic [39:0]         dmag_c;
  logic [127:0]        sq_shift;
  logic [VAR_W-1:0]    qsq_c;
  logic [127:0]        div_num;
  logic [63:0]         div_den;
  logic                mul_go;
  logic [63:0]         mul_a, mul_b;
  logic [VAR_W:0]      vsum;
  logic [63:0]         sqrt_in;
  logic [32:0]         wsum;

  always_comb begin
    case (cmd.idx)
      2'd0:    pos_sel = h.pos_x;
      2'd1:    pos_sel = h.pos_y;
      2'd2:    pos_sel = h.pos_z;
      default: pos_sel = h.path_s;
    endcase
  end

  assign diff   = {pos_sel[23], pos_sel, 16'b0} - {cen[cmd.idx][39], cen[cmd.idx]};
  assign dmag_c = diff[40] ? 40'(-diff) : diff[39:0];

  // square of the offset, rounded half up to the variance format
  assign sq_shift = (acc + (128'(1) << (SQ_SH - 1))) >> SQ_SH;
  assign qsq_c    = (|sq_shift[127:VAR_W]) ? VAR_MAX : sq_shift[VAR_W-1:0];

  assign wsum    = 33'(cs) + 33'(h.hit_charge);
  assign sqrt_in = (64'(vr[cmd.idx]) << SH_L) >> SH_R;
  assign vsum    = (VAR_W+1)'(term) + (sts.cnt_one ? '0 : (VAR_W+1)'(dq));

  always_comb begin
    mul_go = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_CMUL: begin
        mul_a = 64'(h.hit_charge);
        mul_b = 64'(dmag_c);
      end
      OP_WW_MUL: begin
        mul_a = 64'(h.hit_charge);
        mul_b = 64'(wo);
      end
      OP_WN2_MUL: begin
        mul_a = 64'(wn);
        mul_b = 64'(wn);
      end
      OP_SQ_MUL: begin
        mul_a = 64'(dmag[cmd.idx]);
        mul_b = 64'(dmag[cmd.idx]);
      end
      OP_TM_MUL: begin
        mul_a = 64'(qsq_c);
        mul_b = 64'(ww);
      end
      OP_OV_MUL: begin
        mul_a = 64'(wo);
        mul_b = 64'(vr[cmd.idx]);
      end
      default: mul_go = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_TM_DIV) begin
      div_den = wn2;
    end else begin
      div_den = 64'(wn);
    end
    div_num = acc + 128'(div_den >> 1);
  end

  // multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (mul_go) begin
        ma    <= mul_a;
        mb    <= mul_b;
        acc   <= '0;
        mcnt  <= 2'd0;
        mbusy <= 1'b1;
      end else if (mbusy) begin
        acc  <= acc + (128'(ma * mb[{mcnt, 4'b0} +: 16]) << {mcnt, 4'b0});
        mcnt <= mcnt + 2'd1;
        if (mcnt == 2'd3) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  // divider; a quotient wider than 48 bits saturates
  always_ff @(posedge clk) begin
    logic [64:0] t;
    logic        ge;
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      t  = {rem, dlow[47]};
      ge = (t >= {1'b0, dd});
      if (cmd.op == OP_CDIV || cmd.op == OP_TM_DIV || cmd.op == OP_OV_DIV) begin
        dd <= div_den;
        if (div_num[127:48] >= 80'(div_den)) begin
          dq    <= VAR_MAX;
          ddone <= 1'b1;
        end else begin
          rem   <= div_num[111:48];
          dlow  <= div_num[47:0];
          dq    <= '0;
          dcnt  <= '0;
          dbusy <= 1'b1;
        end
      end else if (dbusy) begin
        rem  <= ge ? 64'(t - {1'b0, dd}) : t[63:0];
        dq   <= {dq[46:0], ge};
        dlow <= {dlow[46:0], 1'b0};
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'd47) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  // square root by the digit-by-digit method
  always_ff @(posedge clk) begin
    logic [63:0] trial;
    if (rst) begin
      sbusy <= 1'b0;
      sdone <= 1'b0;
    end else begin
      sdone <= 1'b0;
      trial = sr + sb;
      if (cmd.op == OP_SQRT) begin
        sv    <= sqrt_in;
        sr    <= '0;
        sb    <= 64'h4000_0000_0000_0000;
        scnt  <= '0;
        sbusy <= 1'b1;
      end else if (sbusy) begin
        if (sv >= trial) begin
          sv <= sv - trial;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb   <= sb >> 2;
        scnt <= scnt + 5'd1;
        if (scnt == 5'd31) begin
          sbusy <= 1'b0;
          sdone <= 1'b1;
        end
      end
    end
  end

  function automatic logic [23:0] mean_out(input logic signed [39:0] c);
    logic signed [40:0] t;
    t = {c[39], c} + 41'sd32768;
    return t[39:16];
  endfunction

  // cluster state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cs  <= '0;
      cnt <= '0;
      emb <= 1'b0;
      for (int i = 0; i < 4; i++) cen[i] <= '0;
      for (int i = 0; i < 3; i++) vr[i] <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          h <= hit_data;
          if (hit_data.first_hit) begin
            cs  <= '0;
            cnt <= '0;
            emb <= 1'b0;
            for (int i = 0; i < 4; i++) cen[i] <= '0;
            for (int i = 0; i < 3; i++) vr[i] <= '0;
          end
        end
        OP_PREP: begin
          wo <= cs;
          wn <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        end
        OP_CMUL: begin
          dneg <= diff[40];
          if (cmd.idx != 2'd3) dmag[cmd.idx] <= dmag_c;
        end
        OP_CUPD: begin
          cen[cmd.idx] <= dneg ? cen[cmd.idx] - 40'(dq) : cen[cmd.idx] + 40'(dq);
        end
        OP_VDEF: begin
          vr[0] <= DEF_VAR_X;
          vr[1] <= DEF_VAR_Y;
          vr[2] <= DEF_VAR_Z;
        end
        OP_WN2_MUL: ww  <= acc[51:0];
        OP_WN2_WB:  wn2 <= acc[63:0];
        OP_TM_WB:   term <= dq;
        OP_VUPD: begin
          vr[cmd.idx] <= vsum[VAR_W] ? VAR_MAX : vsum[VAR_W-1:0];
        end
        OP_COMMIT: begin
          if (h.fixed_axis == AXIS_LAYER || h.fixed_axis == AXIS_BOTH) begin
            vr[2] <= DEF_VAR_Z;
          end else if (h.fixed_axis == AXIS_ROW) begin
            vr[0] <= DEF_VAR_X;
          end
          cs  <= wn;
          emb <= h.embed_in;
          if (cnt != '1) cnt <= cnt + COUNT_BITS'(1);
        end
        OP_SG_WB: begin
          sig[cmd.idx] <= (sr > 64'(SIGMA_MAX)) ? SIGMA_MAX : sr[SIG_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      res_valid             <= 1'b1;
      res_data.mean_x       <= mean_out(cen[0]);
      res_data.mean_y       <= mean_out(cen[1]);
      res_data.mean_z       <= mean_out(cen[2]);
      res_data.mean_s       <= mean_out(cen[3]);
      res_data.sigma_x      <= sig[0];
      res_data.sigma_y      <= sig[1];
      res_data.sigma_z      <= sig[2];
      res_data.total_charge <= cs;
      res_data.hit_count    <= (33'(cnt) > 33'h0FFFF) ? 16'hFFFF : 16'(cnt);
      res_data.embed_out    <= emb;
      res_data.bad_charge   <= (h.hit_charge == '0);
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign sts.bad       = (h.hit_charge == '0);
  assign sts.cnt_zero  = (cnt == '0);
  assign sts.cnt_one   = (cnt == COUNT_BITS'(1));
  assign sts.mul_done  = mdone;
  assign sts.div_done  = ddone;
  assign sts.sqrt_done = sdone;
  assign sts.out_free  = !res_valid || res_ready;

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mbusy, dbusy, sbusy}))
    else $error("two arithmetic units busy at once");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> res_valid)
    else $error("summary not presented after emit");
  a_commit_good: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_COMMIT |-> !sts.bad)
    else $error("zero-charge hit committed to the cluster");

endmodule
`default_nettype wire

// ===== rtl/weighted_centroid_covariance.sv =====
// Top level: charge-weighted centroid and variance of a cluster of hits.
`default_nettype none
// Takes one hit per input transaction and returns one summary transaction per
// hit: the charge-weighted means of x, y, z and s (rounded half up, same Q
// format as the positions), the x, y, z sigmas (floor of the square root of
// the variance, saturating), the saturating charge sum, the hit count and the
// embed flag of the last good hit. first_hit clears the cluster before the
// hit is used. The first hit of a cluster seeds variances of 16, 1 and 36 mm^2,
// the second gives the two-point weighted variance, later hits the running
// weighted update. A layer cluster (fixed_axis 1 or 3) pins the z variance to
// 36 mm^2, a row cluster (2) pins the x variance to 16 mm^2. A hit with zero
// charge leaves the cluster alone and returns the stored summary with
// bad_charge set. One hit is worked on at a time; the input is ready again
// once the summary sits in the output register, even if it has not been taken.
// The divider produces one quotient bit per cycle for a 48-bit quotient, the
// square root one result bit per cycle, and the 64x16 multiplier works through
// the second operand in 16-bit slices.
module weighted_centroid_covariance #(
  parameter int POS_FRAC_BITS = wcc_pkg::DEF_POS_FRAC_BITS,
  parameter int COUNT_BITS    = wcc_pkg::DEF_COUNT_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  wcc_hit_if.sink   hit,
  wcc_res_if.source res
);
  import wcc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic hit_ready;
  logic res_valid;
  res_t res_data;

  // sequencer: one command per cycle to the datapath
  wcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hit_valid (hit.valid),
    .hit_ready (hit_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: state, arithmetic units and output register
  wcc_dp #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .hit_data  (hit.data),
    .sts       (sts),
    .res_data  (res_data),
    .res_valid (res_valid),
    .res_ready (res.ready)
  );

  assign hit.ready = hit_ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule
`default_nettype wire

// ===== tb/wcc_checker.sv =====
// Checker: predicts each cluster summary from the accepted hits and compares.
`timescale 1ns / 1ps
module wcc_checker
  import wcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wcc_hit_if        hit,
  wcc_res_if        res,
  output int        fail_count,
  output int        pending
);

  logic [31:0] charge_acc;
  longint      cen_acc [4];
  logic [47:0] var_acc [3];
  logic [15:0] hits_seen;
  logic        embed_acc;
  res_t        summary_q [$];

  function automatic logic [127:0] div_half_up(logic [127:0] n, logic [127:0] d);
    return (n + (d >> 1)) / d;
  endfunction

  function automatic logic [47:0] clip48(logic [127:0] v);
    return (v > 128'(VAR_MAX)) ? VAR_MAX : v[47:0];
  endfunction

  function automatic logic [22:0] sigma_of(logic [47:0] v);
    longint unsigned rem, root, b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  -= root + b;
        root  = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return (root > 64'(SIGMA_MAX)) ? SIGMA_MAX : root[22:0];
  endfunction

  function automatic logic [23:0] mean_of(longint c);
    longint t;
    t = (c + 64'sd32768) >>> CEN_EXTRA;
    return t[23:0];
  endfunction

  // advance the cluster by one hit and return the summary it produces
  function automatic res_t cluster_update(hit_t h);
    res_t         r;
    logic [127:0] w, wo, wn, mag, sq, term, sum;
    longint       pos [4];
    longint       diff [3];
    longint       dl, num, nmag, step;
    logic [47:0]  def_var [3];
    def_var = '{DEF_VAR_X, DEF_VAR_Y, DEF_VAR_Z};
    if (h.first_hit) begin
      charge_acc = '0;
      cen_acc    = '{0, 0, 0, 0};
      var_acc    = '{48'd0, 48'd0, 48'd0};
      hits_seen  = '0;
      embed_acc  = 1'b0;
    end
    r = '0;
    w = 128'(h.hit_charge);
    if (w == 0) begin
      r.bad_charge = 1'b1;
    end else begin
      wo = 128'(charge_acc);
      wn = wo + w;
      if (wn > 128'hFFFF_FFFF) wn = 128'hFFFF_FFFF;
      pos = '{longint'(h.pos_x), longint'(h.pos_y), longint'(h.pos_z), longint'(h.path_s)};
      for (int i = 0; i < 4; i++) begin
        dl = pos[i] * 65536 - cen_acc[i];
        if (i < 3) diff[i] = dl;
        num  = longint'(h.hit_charge) * dl;
        nmag = (num < 0) ? -num : num;
        step = (nmag + longint'(wn[63:0] >> 1)) / longint'(wn[63:0]);
        cen_acc[i] += (num < 0) ? -step : step;
      end
      for (int i = 0; i < 3; i++) begin
        if (hits_seen == 0) begin
          var_acc[i] = def_var[i];
        end else begin
          mag  = 128'((diff[i] < 0) ? -diff[i] : diff[i]);
          sq   = clip48(div_half_up(mag * mag, 128'd1 << 32));
          term = clip48(div_half_up(sq * (w * wo), wn * wn));
          sum  = term;
          if (hits_seen != 1) sum += clip48(div_half_up(wo * 128'(var_acc[i]), wn));
          var_acc[i] = clip48(sum);
        end
      end
      // layer type (and code three) pins z, row type pins x
      if (h.fixed_axis == AXIS_LAYER || h.fixed_axis == AXIS_BOTH) var_acc[2] = DEF_VAR_Z;
      else if (h.fixed_axis == AXIS_ROW) var_acc[0] = DEF_VAR_X;
      charge_acc = wn[31:0];
      if (hits_seen != 16'hFFFF) hits_seen++;
      embed_acc = h.embed_in;
    end
    r.mean_x       = mean_of(cen_acc[0]);
    r.mean_y       = mean_of(cen_acc[1]);
    r.mean_z       = mean_of(cen_acc[2]);
    r.mean_s       = mean_of(cen_acc[3]);
    r.sigma_x      = sigma_of(var_acc[0]);
    r.sigma_y      = sigma_of(var_acc[1]);
    r.sigma_z      = sigma_of(var_acc[2]);
    r.total_charge = charge_acc;
    r.hit_count    = hits_seen;
    r.embed_out    = embed_acc;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = summary_q.size();

  initial begin
    fail_count = 0;
    charge_acc = '0;
    cen_acc    = '{0, 0, 0, 0};
    var_acc    = '{48'd0, 48'd0, 48'd0};
    hits_seen  = '0;
    embed_acc  = 1'b0;
  end

  always @(posedge clk) begin
    res_t e, a;
    if (!rst) begin
      // the result leaving at this edge is always older than a hit entering
      if (res.valid && res.ready) begin
        a = res.data;
        if (summary_q.size() == 0) begin
          $display("%0t unexpected summary, expected none actual %h", $time, a);
          fail_count++;
        end else begin
          e = summary_q.pop_front();
          check_field("mean_x", 24'(e.mean_x), 24'(a.mean_x));
          check_field("mean_y", 24'(e.mean_y), 24'(a.mean_y));
          check_field("mean_z", 24'(e.mean_z), 24'(a.mean_z));
          check_field("mean_s", 24'(e.mean_s), 24'(a.mean_s));
          check_field("sigma_x", e.sigma_x, a.sigma_x);
          check_field("sigma_y", e.sigma_y, a.sigma_y);
          check_field("sigma_z", e.sigma_z, a.sigma_z);
          check_field("total_charge", e.total_charge, a.total_charge);
          check_field("hit_count", e.hit_count, a.hit_count);
          check_field("embed_out", e.embed_out, a.embed_out);
          check_field("bad_charge", e.bad_charge, a.bad_charge);
        end
      end
      if (hit.valid && hit.ready) summary_q.insert(summary_q.size(), cluster_update(hit.data));
    end
  end

endmodule

// ===== tb/weighted_centroid_covariance_tb.sv =====
// Testbench top: hit stimulus, output back-pressure and the final verdict.
`timescale 1ns / 1ps
module weighted_centroid_covariance_tb;
  import wcc_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   burst_left;
  bit   stim_done;

  wcc_hit_if hit_ch ();
  wcc_res_if res_ch ();

  weighted_centroid_covariance u_top (
    .clk (clk),
    .rst (rst),
    .hit (hit_ch.sink),
    .res (res_ch.source)
  );

  // prediction and comparison live in the checker; only the failure and pending counts come back
  wcc_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .hit        (hit_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Position mix: mostly within +-512 mm so variances stay meaningful, sometimes
  // zero, the rails (drives variance saturation) or fully random bits.
  function automatic logic signed [23:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return -24'sh800000;
      2:       return 24'(longint'($urandom()));
      3:       return 24'sd0;
      default: return 24'($signed(18'($urandom())));
    endcase
  endfunction

  function automatic logic [19:0] pick_charge();
    case ($urandom_range(0, 14))
      0:       return 20'd0;            // rejected hit
      1:       return 20'hFFFFF;
      2:       return 20'd1;
      3:       return 20'($urandom());
      default: return 20'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic hit_t rand_hit(logic first);
    hit_t h;
    h.first_hit  = first;
    h.pos_x      = pick_pos();
    h.pos_y      = pick_pos();
    h.pos_z      = pick_pos();
    h.path_s     = pick_pos();
    h.hit_charge = pick_charge();
    h.fixed_axis = 2'($urandom_range(0, 3));
    h.embed_in   = 1'($urandom());
    return h;
  endfunction

  function automatic hit_t mk_hit(logic first, int x, int y, int z, int s,
                                  logic [19:0] q, logic [1:0] ax, logic emb);
    hit_t h;
    h = '{first, 24'(x), 24'(y), 24'(z), 24'(s), q, ax, emb};
    return h;
  endfunction

  // Sender: bursts of transactions separated by random gaps. valid stays high
  // across back-to-back transactions inside a burst.
  task automatic send_hit(hit_t h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        hit_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data  <= h;
    do @(posedge clk); while (!hit_ch.ready);
    burst_left--;
  endtask

  // Receiver: random stalls, stretches of always-ready, and one long
  // hold-off so the output register fills and the input side stalls.
  initial begin
    int cyc;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 30000) begin
        res_ch.ready <= 1'b0;
        repeat (6000) @(posedge clk);
        cyc++;
      end
      if ((cyc / 20000) % 3 == 1) res_ch.ready <= 1'b1;
      else res_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int len;
    int sent;
    hit_ch.valid <= 1'b0;
    hit_ch.data  <= '0;
    rst          <= 1'b1;
    burst_left   = 0;
    stim_done    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: seeding, rejection, extremes, every cluster type, second hit
    send_hit(mk_hit(1, 0, 0, 0, 0, 20'd0, AXIS_NONE, 1));       // zero charge on empty
    send_hit(mk_hit(1, 256, 512, -768, 1024, 20'd100, AXIS_NONE, 1));
    send_hit(mk_hit(0, 1280, 0, 768, 0, 20'd300, AXIS_NONE, 0));
    send_hit(mk_hit(0, -2560, 256, 0, 5, 20'd50, AXIS_LAYER, 1));
    send_hit(mk_hit(0, 0, 0, 0, 0, 20'd0, AXIS_ROW, 0));         // rejected mid cluster
    send_hit(mk_hit(0, 100, -100, 100, -100, 20'd7, AXIS_ROW, 0));
    send_hit(mk_hit(0, 3, 3, 3, 3, 20'd9, AXIS_BOTH, 1));
    send_hit(mk_hit(1, 8388607, 8388607, 8388607, 8388607, 20'hFFFFF, AXIS_NONE, 0));
    send_hit(mk_hit(0, -8388608, -8388608, -8388608, -8388608, 20'hFFFFF, AXIS_NONE, 1));
    send_hit(mk_hit(0, 8388607, -8388608, 8388607, 0, 20'd1, AXIS_NONE, 0));
    send_hit(mk_hit(0, -8388608, 8388607, 0, 8388607, 20'hFFFFF, AXIS_NONE, 1));
    send_hit(mk_hit(1, -8388608, 0, 8388607, -1, 20'd1, AXIS_BOTH, 1));
    send_hit(mk_hit(0, 8388607, 1, -8388608, 1, 20'hFFFFF, AXIS_LAYER, 0));
    send_hit(mk_hit(1, 1, -1, 1, -1, 20'd1, AXIS_ROW, 1));
    send_hit(mk_hit(0, -1, 1, -1, 1, 20'd1, AXIS_ROW, 0));
    send_hit(mk_hit(0, 0, 0, 0, 0, 20'd2, AXIS_NONE, 1));
    send_hit(mk_hit(1, 12345, -6789, 4242, 777, 20'd0, AXIS_LAYER, 1)); // clear then reject

    // random: clusters of random length, some hits restarting mid-stream
    sent = 0;
    while (sent < 550) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        send_hit(rand_hit(k == 0 || $urandom_range(0, 19) == 0));
        sent++;
      end
    end
    hit_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    @(posedge stim_done);
    // let the checker record the last accepted hit before looking at pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) begin
      $display("weighted_centroid_covariance regression: pass");
    end else begin
      $display("weighted_centroid_covariance regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("weighted_centroid_covariance regression: fail");
    $finish;
  end

endmodule
